>>> rtl/fbrci_pkg.sv
package fbrci_pkg;

  // Frame store geometry
  localparam int unsigned COLUMNS = 128;
  localparam int unsigned PAGES   = 8;
  localparam int unsigned DEPTH   = COLUMNS * PAGES;

  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned ROW_W  = PAGE_W + 3;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  localparam int unsigned COORD_W = 10;
  localparam logic [7:0]  FULL_MASK = 8'hFF;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INVERT = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // Controller to datapath
  typedef struct packed {
    logic sweep;    // write zeros at the sweep address
    logic load;     // capture a new request
    logic step;     // issue one read-modify-write of the rectangle
    logic rd;       // issue the byte read
    logic respond;  // present the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic run_last;
    logic go_rect;
    logic go_read;
  } status_t;

endpackage

>>> rtl/framebuffer_rect_clear_invert_top.sv
// Clear/invert walks the W columns of each of the P pages, then a flush state, then the result
// strobe; read passes a store-read state, an empty rectangle or unused mode goes to the strobe.
// One request in flight at a time. The walk read-modify-writes one byte per cycle.
// Reset: asynchronous, active low; a clearing pass then zeroes all 1024 bytes with busy_o
// high. The receiver cannot stall: done_o marks each result for one cycle.
module framebuffer_rect_clear_invert_top
  import fbrci_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                mode_i,
  input  logic signed [COORD_W-1:0] left_i,
  input  logic signed [COORD_W-1:0] top_i,
  input  logic signed [COORD_W-1:0] right_i,
  input  logic signed [COORD_W-1:0] bottom_i,
  input  logic [6:0]                read_column_i,
  input  logic [2:0]                read_page_i,
  output logic                      done_o,
  output logic [7:0]                read_data_o,
  output logic                      empty_area_o,
  output logic                      refresh_pending_o
);

  // Commands down to the datapath, status back to the controller
  cmd_t    cmd;
  status_t status;

  // Sequence the clearing pass, the rectangle walk, the byte read and the result strobe
  fbrci_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Hold the frame store, clamp the request and run the read-modify-write pipeline
  fbrci_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .mode_i            (mode_i),
    .left_i            (left_i),
    .top_i             (top_i),
    .right_i           (right_i),
    .bottom_i          (bottom_i),
    .read_column_i     (read_column_i),
    .read_page_i       (read_page_i),
    .read_data_o       (read_data_o),
    .empty_area_o      (empty_area_o),
    .refresh_pending_o (refresh_pending_o)
  );

  // The result strobe comes straight from the controller's response state
  assign done_o = cmd.respond;

endmodule

>>> rtl/fbrci_ctrl.sv
module fbrci_ctrl
  import fbrci_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  typedef enum logic [5:0] {
    ST_SWEEP = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RUN   = 6'b000100,
    ST_FLUSH = 6'b001000,
    ST_RDMEM = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (status_i.go_rect) begin
            state_d = ST_RUN;
          end else if (status_i.go_read) begin
            state_d = ST_RDMEM;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (status_i.run_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_RESP;
      end
      ST_RDMEM: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_resp_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.respond |=> !cmd_o.respond && !busy_o)
    else $error("result strobe not followed by idle");

  a_sweep_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sweep |=> cmd_o.sweep || state_q == ST_IDLE)
    else $error("clearing pass left to a state other than idle");

endmodule

>>> rtl/fbrci_dp.sv
module fbrci_dp
  import fbrci_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  input  logic [1:0]                mode_i,
  input  logic signed [COORD_W-1:0] left_i,
  input  logic signed [COORD_W-1:0] top_i,
  input  logic signed [COORD_W-1:0] right_i,
  input  logic signed [COORD_W-1:0] bottom_i,
  input  logic [6:0]                read_column_i,
  input  logic [2:0]                read_page_i,
  output logic [7:0]                read_data_o,
  output logic                      empty_area_o,
  output logic                      refresh_pending_o
);

  localparam logic signed [COORD_W-1:0] COL_MAX = COORD_W'(COLUMNS - 1);
  localparam logic signed [COORD_W-1:0] ROW_MAX = COORD_W'(8 * PAGES - 1);

  logic [7:0] mem [DEPTH];

  // Request clamping
  logic [COL_W-1:0]          lc, rc;
  logic signed [COORD_W-1:0] tc, bc, bm1;
  logic                      is_rect, empty, rd_ok;
  logic [ADDR_W-1:0]         rd_addr;

  always_comb begin
    if (left_i < 0)             lc = '0;
    else if (left_i > COL_MAX)  lc = COL_MAX[COL_W-1:0];
    else                        lc = left_i[COL_W-1:0];
    if (right_i < 0)            rc = '0;
    else if (right_i > COL_MAX) rc = COL_MAX[COL_W-1:0];
    else                        rc = right_i[COL_W-1:0];
    tc  = (top_i < 0) ? '0 : top_i;
    bc  = (bottom_i > ROW_MAX) ? ROW_MAX : bottom_i;
    bm1 = bc - COORD_W'(1);
    is_rect = mode_i inside {MODE_CLEAR, MODE_INVERT};
    empty   = (lc >= rc) || (tc >= bc);
    rd_ok   = (32'(read_column_i) < COLUMNS) && (32'(read_page_i) < PAGES);
    rd_addr = rd_ok ? ADDR_W'(ADDR_W'(read_page_i) * ADDR_W'(COLUMNS) + ADDR_W'(read_column_i))
                    : '0;
  end

  assign status_o.go_rect = is_rect && !empty;
  assign status_o.go_read = (mode_i == MODE_READ);

  // Captured request
  mode_e             mode_q;
  logic [COL_W-1:0]  lc_q, rc_q, col_q;
  logic [PAGE_W-1:0] fp_q, lp_q, page_q;
  logic [7:0]        fmask_q, lmask_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              rd_ok_q, empty_q, dirty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= 1'b0;
    end else if (cmd_i.load && is_rect && !empty) begin
      dirty_q <= 1'b1;
    end
  end

  logic col_wrap;
  assign col_wrap = ((COL_W + 1)'(col_q) + (COL_W + 1)'(1)) == (COL_W + 1)'(rc_q);
  assign status_o.run_last = col_wrap && (page_q == lp_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= mode_e'(mode_i);
      lc_q      <= lc;
      rc_q      <= rc;
      col_q     <= lc;
      fp_q      <= tc[ROW_W-1:3];
      page_q    <= tc[ROW_W-1:3];
      lp_q      <= bm1[ROW_W-1:3];
      fmask_q   <= FULL_MASK << tc[2:0];
      lmask_q   <= (bc[2:0] == 3'd0) ? FULL_MASK
                                     : FULL_MASK >> (4'd8 - {1'b0, bc[2:0]});
      rd_addr_q <= rd_addr;
      rd_ok_q   <= rd_ok;
      empty_q   <= is_rect && empty;
    end else if (cmd_i.step) begin
      if (col_wrap) begin
        col_q  <= lc_q;
        page_q <= PAGE_W'(page_q + 1'b1);
      end else begin
        col_q <= COL_W'(col_q + 1'b1);
      end
    end
  end

  // Clearing pass counter
  logic [ADDR_W-1:0] sweep_q;
  assign status_o.sweep_last = (sweep_q == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= ADDR_W'(sweep_q + 1'b1);
    end
  end

  // Read-modify-write pipeline: read now, write back next cycle
  logic [ADDR_W-1:0] run_addr, raddr, waddr_q;
  logic [7:0]        page_mask, mask_q, rdata_q, wdata;
  logic              wen_q, inv_q;

  assign run_addr  = ADDR_W'(ADDR_W'(page_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q));
  assign raddr     = cmd_i.step ? run_addr : rd_addr_q;
  assign page_mask = ((page_q == fp_q) ? fmask_q : FULL_MASK)
                   & ((page_q == lp_q) ? lmask_q : FULL_MASK);
  assign wdata     = inv_q ? (rdata_q ^ mask_q) : (rdata_q & ~mask_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wen_q <= 1'b0;
    end else begin
      wen_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_q <= run_addr;
    mask_q  <= page_mask;
    inv_q   <= (mode_q == MODE_INVERT);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      mem[sweep_q] <= '0;
    end else if (wen_q) begin
      mem[waddr_q] <= wdata;
    end
    if (cmd_i.step || cmd_i.rd) begin
      rdata_q <= mem[raddr];
    end
  end

  assign read_data_o       = (mode_q == MODE_READ && rd_ok_q) ? rdata_q : '0;
  assign empty_area_o      = empty_q;
  assign refresh_pending_o = dirty_q;

  a_step_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (page_q >= fp_q) && (page_q <= lp_q))
    else $error("rectangle walk outside its pages");

  a_step_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (col_q >= lc_q) && (col_q < rc_q))
    else $error("rectangle walk outside its columns");

  a_wb_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wen_q |-> !cmd_i.sweep && !cmd_i.load)
    else $error("write-back collides with sweep or load");

endmodule

>>> tb/framebuffer_rect_clear_invert_top_tb.sv
module framebuffer_rect_clear_invert_top_tb;
  import fbrci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Signed copies of the geometry, so that clamping compares as int and not as unsigned
  localparam int NCOL  = COLUMNS;
  localparam int NPAGE = PAGES;
  localparam int NROW  = 8 * PAGES;

  // Longest rectangle walk is 127 columns by 8 pages, plus its flush and result states
  localparam int DRAIN_CYCLES = 1100;

  typedef struct {
    mode_e                     mode;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [6:0]                read_column;
    logic [2:0]                read_page;
  } request_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       empty_area;
    logic       refresh_pending;
  } result_t;

  logic                      clk_i             = 1'b0;
  logic                      rst_ni            = 1'b0;
  logic                      start_i           = 1'b0;
  logic [1:0]                mode_i            = '0;
  logic signed [COORD_W-1:0] left_i            = '0;
  logic signed [COORD_W-1:0] top_i             = '0;
  logic signed [COORD_W-1:0] right_i           = '0;
  logic signed [COORD_W-1:0] bottom_i          = '0;
  logic [6:0]                read_column_i     = '0;
  logic [2:0]                read_page_i       = '0;
  logic                      busy_o;
  logic                      done_o;
  logic [7:0]                read_data_o;
  logic                      empty_area_o;
  logic                      refresh_pending_o;

  framebuffer_rect_clear_invert_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .mode_i            (mode_i),
    .left_i            (left_i),
    .top_i             (top_i),
    .right_i           (right_i),
    .bottom_i          (bottom_i),
    .read_column_i     (read_column_i),
    .read_page_i       (read_page_i),
    .done_o            (done_o),
    .read_data_o       (read_data_o),
    .empty_area_o      (empty_area_o),
    .refresh_pending_o (refresh_pending_o)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be sent, and results owed by the block, oldest first
  request_t queued_requests[$];
  result_t  owed_results[$];

  // Shadow copy of the frame store and its dirty flag
  logic [7:0] shadow_frame [NPAGE][NCOL];
  logic       shadow_dirty;

  int   sender_idle_pct = 31;
  logic request_taken   = 1'b0;
  int   mismatch_count  = 0;
  int   results_checked = 0;
  int   empty_seen      = 0;
  int   mode_count [4]  = '{default: 0};

  function automatic int clamp_column(int v);
    if (v < 0) return 0;
    if (v > NCOL - 1) return NCOL - 1;
    return v;
  endfunction

  // Apply one request to the shadow frame and work out the result it owes
  task automatic apply_to_shadow_frame(input request_t rq, output result_t res);
    int         l, t, r, b, first_pg, end_pg;
    logic [7:0] mask;
    res = '0;
    case (rq.mode)
      MODE_CLEAR, MODE_INVERT: begin
        l = clamp_column(int'(rq.left));
        r = clamp_column(int'(rq.right));
        t = int'(rq.top);
        b = int'(rq.bottom);
        if (t < 0) t = 0;
        if (b > NROW - 1) b = NROW - 1;
        if (l >= r || t >= b) begin
          // nothing touched, dirty flag left alone
          res.empty_area = 1'b1;
        end else begin
          first_pg = t / 8;
          end_pg   = (b + 7) / 8;
          if (end_pg > NPAGE) end_pg = NPAGE;
          for (int p = first_pg; p < end_pg; p++) begin
            // trim the top page from below and the bottom page from above;
            // a single page gets both trims, for clear as well as invert
            mask = FULL_MASK;
            if (p == first_pg && (t % 8) != 0) mask &= FULL_MASK << (t % 8);
            if (p == end_pg - 1 && (b % 8) != 0) mask &= FULL_MASK >> (8 - (b % 8));
            for (int c = l; c < r; c++) begin
              if (rq.mode == MODE_INVERT) shadow_frame[p][c] ^= mask;
              else shadow_frame[p][c] &= ~mask;
            end
          end
          shadow_dirty = 1'b1;
        end
      end
      MODE_READ: begin
        res.read_data = shadow_frame[rq.read_page][rq.read_column];
      end
      default: ;
    endcase
    res.refresh_pending = shadow_dirty;
  endtask

  function automatic request_t rect_request(mode_e m, int l, int t, int r, int b);
    request_t rq;
    rq.mode        = m;
    rq.left        = COORD_W'(l);
    rq.top         = COORD_W'(t);
    rq.right       = COORD_W'(r);
    rq.bottom      = COORD_W'(b);
    // read fields are don't-care here, so let them wander
    rq.read_column = 7'($urandom);
    rq.read_page   = 3'($urandom);
    return rq;
  endfunction

  function automatic request_t read_request(int c, int p);
    request_t rq;
    rq = rect_request(MODE_READ, int'($urandom), int'($urandom), int'($urandom),
                      int'($urandom));
    rq.read_column = 7'(c);
    rq.read_page   = 3'(p);
    return rq;
  endfunction

  // Reads, unused modes, rectangles: mostly small so runs stay short, some wide or noise
  function automatic request_t random_request();
    int    sel, shape, l, t, w, h;
    mode_e m;
    sel = $urandom_range(0, 99);
    if (sel < 38) return read_request($urandom_range(0, 127), $urandom_range(0, 7));
    if (sel < 41) return rect_request(MODE_NONE, int'($urandom), int'($urandom),
                                      int'($urandom), int'($urandom));
    m     = (sel < 70) ? MODE_INVERT : MODE_CLEAR;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      return rect_request(m, int'($urandom), int'($urandom), int'($urandom),
                          int'($urandom));
    end else if (shape < 8) begin
      l = int'($urandom_range(0, 133)) - 4;
      w = int'($urandom_range(0, 12));
      t = int'($urandom_range(0, 70)) - 4;
      h = int'($urandom_range(0, 22)) - 1;
      return rect_request(m, l, t, l + w, t + h);
    end else begin
      l = int'($urandom_range(0, 40)) - 8;
      w = int'($urandom_range(30, 150));
      t = int'($urandom_range(0, 40)) - 8;
      h = int'($urandom_range(8, 80));
      return rect_request(m, l, t, l + w, t + h);
    end
  endfunction

  task automatic wait_drained();
    while (queued_requests.size() != 0 || owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Driver: present the oldest queued request at the falling edge, hold it until taken,
  // and idle at random between requests
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !request_taken)) begin
      if (queued_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        mode_i        <= queued_requests[0].mode;
        left_i        <= queued_requests[0].left;
        top_i         <= queued_requests[0].top;
        right_i       <= queued_requests[0].right;
        bottom_i      <= queued_requests[0].bottom;
        read_column_i <= queued_requests[0].read_column;
        read_page_i   <= queued_requests[0].read_page;
        start_i       <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check any result strobe against the oldest owed result, then record a
  // request taken at this edge and predict what it owes
  always @(posedge clk_i) begin
    request_t rq;
    result_t  want;
    if (rst_ni) begin
      request_taken <= start_i && !busy_o;
      if (done_o) begin
        if (owed_results.size() == 0) begin
          $error("result strobe with no request outstanding");
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          results_checked++;
          if (read_data_o !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, read_data_o);
            mismatch_count++;
          end
          if (empty_area_o !== want.empty_area) begin
            $error("empty_area: expected %0b, got %0b", want.empty_area, empty_area_o);
            mismatch_count++;
          end
          if (refresh_pending_o !== want.refresh_pending) begin
            $error("refresh_pending: expected %0b, got %0b", want.refresh_pending,
                   refresh_pending_o);
            mismatch_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        rq.mode        = mode_e'(mode_i);
        rq.left        = left_i;
        rq.top         = top_i;
        rq.right       = right_i;
        rq.bottom      = bottom_i;
        rq.read_column = read_column_i;
        rq.read_page   = read_page_i;
        apply_to_shadow_frame(rq, want);
        owed_results.push_back(want);
        mode_count[rq.mode]++;
        if (want.empty_area) empty_seen++;
        void'(queued_requests.pop_front());
      end
    end
  end

  initial begin
    for (int p = 0; p < NPAGE; p++) begin
      for (int c = 0; c < NCOL; c++) shadow_frame[p][c] = '0;
    end
    shadow_dirty = 1'b0;

    // Hold reset, then release it at a falling edge; the block then sweeps the store with busy high
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: clean store, unused mode, empty cases, clamped full-screen invert,
    // single-page clear and invert, a masked multi-page clear, then a full clear
    sender_idle_pct = 31;
    queued_requests.push_back(read_request(0, 0));
    queued_requests.push_back(read_request(127, 7));
    queued_requests.push_back(rect_request(MODE_NONE, -512, -512, 511, 511));
    queued_requests.push_back(rect_request(MODE_CLEAR, 5, 0, 5, 64));
    queued_requests.push_back(rect_request(MODE_INVERT, -512, -512, 511, 511));
    queued_requests.push_back(read_request(0, 0));
    queued_requests.push_back(read_request(127, 7));
    queued_requests.push_back(read_request(126, 7));
    queued_requests.push_back(read_request(126, 0));
    queued_requests.push_back(rect_request(MODE_CLEAR, 10, 2, 20, 6));
    queued_requests.push_back(read_request(10, 0));
    queued_requests.push_back(read_request(19, 0));
    queued_requests.push_back(read_request(20, 0));
    queued_requests.push_back(rect_request(MODE_INVERT, 30, 8, 31, 13));
    queued_requests.push_back(read_request(30, 1));
    queued_requests.push_back(rect_request(MODE_CLEAR, 40, 5, 43, 20));
    queued_requests.push_back(read_request(41, 0));
    queued_requests.push_back(read_request(41, 1));
    queued_requests.push_back(read_request(41, 2));
    queued_requests.push_back(rect_request(MODE_INVERT, 60, 30, 70, 30));
    queued_requests.push_back(rect_request(MODE_CLEAR, 200, 0, 300, 64));
    queued_requests.push_back(rect_request(MODE_INVERT, 0, 511, 127, -512));
    queued_requests.push_back(rect_request(MODE_NONE, 0, 0, 127, 63));
    queued_requests.push_back(rect_request(MODE_CLEAR, -1, -1, 128, 64));
    queued_requests.push_back(read_request(126, 7));
    // Wait until every request is sent and every owed result is back
    wait_drained();

    // Random, sender idling often
    for (int i = 0; i < 200; i++) queued_requests.push_back(random_request());
    wait_drained();

    // Random, sender idling most of the time
    sender_idle_pct = 83;
    for (int i = 0; i < 200; i++) queued_requests.push_back(random_request());
    wait_drained();

    // Random, back to back
    sender_idle_pct = 0;
    for (int i = 0; i < 180; i++) queued_requests.push_back(random_request());
    wait_drained();

    // Allow a late stray strobe to show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d clear, %0d invert, %0d read, %0d unused mode.",
             mode_count[MODE_CLEAR] + mode_count[MODE_INVERT] + mode_count[MODE_READ]
             + mode_count[MODE_NONE], mode_count[MODE_CLEAR], mode_count[MODE_INVERT],
             mode_count[MODE_READ], mode_count[MODE_NONE]);
    $display("Checked %0d results, %0d of them empty rectangles.", results_checked,
             empty_seen);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
rtl/fbrci_pkg.sv
rtl/fbrci_ctrl.sv
rtl/fbrci_dp.sv
rtl/framebuffer_rect_clear_invert_top.sv
tb/framebuffer_rect_clear_invert_top_tb.sv
